>>> src/symbol_register_pool_allocator_assert.svh
// Assertion macros used by the top-level allocator module.
`ifndef SYMBOL_REGISTER_POOL_ALLOCATOR_ASSERT_SVH
`define SYMBOL_REGISTER_POOL_ALLOCATOR_ASSERT_SVH

// An implication that must hold on every clock edge out of reset.
`define SRPA_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SRPA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

>>> src/srpa_pkg.sv
package srpa_pkg;

	localparam int NUM_REGS = 32;
	localparam int SYMBOL_BITS = 16;
	localparam int REG_IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = 1;

	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_ALLOCATE = 3'd1;
	localparam logic [2:0] OP_LOOKUP = 3'd2;
	localparam logic [2:0] OP_MARK = 3'd3;
	localparam logic [2:0] OP_RELEASE = 3'd4;
	localparam logic [2:0] OP_EVICT = 3'd5;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_POOL_FULL = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_ALREADY_MAPPED = 3'd3;
	localparam logic [2:0] ST_NOTHING_TO_EVICT = 3'd4;

	localparam logic CFG_FIRST_REG = 1'b0;
	localparam logic CFG_LAST_REG = 1'b1;

	localparam logic [4:0] FIRST_REG_RESET = 5'd8;
	localparam logic [4:0] LAST_REG_RESET = 5'd25;

	typedef struct packed {
		logic [2:0] operation;
		logic [15:0] symbol;
	} in_item_t;

	typedef struct packed {
		logic [4:0] register_number;
		logic [2:0] status;
		logic [15:0] evicted_symbol;
		logic free_available;
		logic [31:0] used_mask;
	} out_item_t;

	typedef enum logic [3:0] {
		KIND_NONE = 4'b0001,
		KIND_CLEAR = 4'b0010,
		KIND_SEARCH = 4'b0100,
		KIND_SCAN = 4'b1000
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [2:0] operation;
		logic [SYMBOL_BITS-1:0] symbol;
	} cmd_t;

endpackage

>>> src/srpa_front.sv
module srpa_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input srpa_pkg::in_item_t in_item,
	output logic cmd_valid,
	input logic cmd_take,
	output srpa_pkg::cmd_t cmd
);

	srpa_pkg::cmd_t slot_q [srpa_pkg::QUEUE_DEPTH];
	logic [srpa_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [srpa_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [srpa_pkg::QUEUE_PTR_BITS:0] count_q;
	srpa_pkg::cmd_t new_cmd;
	logic push;
	logic pop;

	always_comb begin
		new_cmd.operation = in_item.operation;
		new_cmd.symbol = in_item.symbol[srpa_pkg::SYMBOL_BITS-1:0];
		case (in_item.operation)
			srpa_pkg::OP_CLEAR: new_cmd.kind = srpa_pkg::KIND_CLEAR;
			srpa_pkg::OP_ALLOCATE, srpa_pkg::OP_LOOKUP, srpa_pkg::OP_MARK:
				new_cmd.kind = srpa_pkg::KIND_SEARCH;
			srpa_pkg::OP_RELEASE, srpa_pkg::OP_EVICT: new_cmd.kind = srpa_pkg::KIND_SCAN;
			default: new_cmd.kind = srpa_pkg::KIND_NONE;
		endcase
	end

	assign in_stall = (count_q == (srpa_pkg::QUEUE_PTR_BITS+1)'(srpa_pkg::QUEUE_DEPTH));
	assign push = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign pop = cmd_valid && cmd_take;
	assign cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (srpa_pkg::QUEUE_PTR_BITS+1)'(push)
				- (srpa_pkg::QUEUE_PTR_BITS+1)'(pop);
		end
	end

endmodule

>>> src/srpa_back.sv
module srpa_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [4:0] cfg_data,
	input logic cmd_valid,
	output logic cmd_take,
	input srpa_pkg::cmd_t cmd,
	output logic out_valid,
	input logic out_stall,
	output srpa_pkg::out_item_t out_item
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_FINISH = 4'b0100,
		ST_SEND = 4'b1000
	} state_t;

	localparam int N = srpa_pkg::NUM_REGS;
	localparam int IB = srpa_pkg::REG_IDX_BITS;
	localparam int SB = srpa_pkg::SYMBOL_BITS;

	state_t state_q;
	srpa_pkg::cmd_t cmd_q;
	logic [4:0] first_reg_q;
	logic [4:0] last_reg_q;
	logic [N-1:0] valid_q;
	logic [N-1:0] marked_q;
	logic [SB-1:0] sym_q [N];
	logic [IB:0] idx_q;
	logic hit_q;
	logic [IB-1:0] hit_idx_q;
	logic best_q;
	logic [IB-1:0] best_idx_q;
	logic [SB-1:0] best_sym_q;
	logic out_valid_q;
	srpa_pkg::out_item_t out_q;

	logic [IB-1:0] idx;
	logic [N-1:0] pool_mask;
	logic [N-1:0] free_vec;
	logic [N-1:0] low_free;
	logic any_free;
	logic [IB-1:0] low_idx;
	logic [N-1:0] valid_next;
	logic [4:0] top;
	logic [31:0] mask32;
	srpa_pkg::out_item_t res;

	assign idx = idx_q[IB-1:0];
	assign top = (32'(last_reg_q) > N - 1) ? 5'(N - 1) : last_reg_q;

	always_comb begin
		for (int r = 0; r < N; r++) begin
			pool_mask[r] = (r >= 32'(first_reg_q)) && (r <= 32'(top));
		end
	end

	assign free_vec = pool_mask & ~valid_q;
	assign low_free = free_vec & (~free_vec + 1'b1);
	assign any_free = |free_vec;

	always_comb begin
		low_idx = '0;
		for (int r = 0; r < N; r++) begin
			if (low_free[r]) begin
				low_idx = IB'(r);
			end
		end
	end

	always_comb begin
		valid_next = valid_q;
		res = '0;
		case (cmd_q.operation)
			srpa_pkg::OP_CLEAR: valid_next = '0;
			srpa_pkg::OP_ALLOCATE: begin
				if (hit_q) begin
					res.status = srpa_pkg::ST_ALREADY_MAPPED;
				end else if (!any_free) begin
					res.status = srpa_pkg::ST_POOL_FULL;
				end else begin
					valid_next[low_idx] = 1'b1;
					res.register_number = 5'(low_idx);
				end
			end
			srpa_pkg::OP_LOOKUP, srpa_pkg::OP_MARK: begin
				if (hit_q) begin
					res.register_number = 5'(hit_idx_q);
				end else begin
					res.status = srpa_pkg::ST_NOT_FOUND;
				end
			end
			srpa_pkg::OP_RELEASE: valid_next = valid_q & marked_q;
			srpa_pkg::OP_EVICT: begin
				if (best_q) begin
					valid_next[best_idx_q] = 1'b0;
					res.register_number = 5'(best_idx_q);
					res.evicted_symbol = 16'(best_sym_q);
				end else begin
					res.status = srpa_pkg::ST_NOTHING_TO_EVICT;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		mask32 = '0;
		for (int r = 0; r < N && r < 32; r++) begin
			mask32[r] = valid_q[r];
		end
	end

	assign cmd_take = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_FINISH && cmd_q.operation == srpa_pkg::OP_ALLOCATE
				&& !hit_q && any_free) begin
			sym_q[low_idx] <= cmd_q.symbol;
		end
		if (state_q == ST_FINISH && (!out_valid_q || !out_stall)) begin
			out_q <= res;
		end
		if (state_q == ST_SEND) begin
			out_q.free_available <= any_free;
			out_q.used_mask <= mask32;
		end
		if (state_q == ST_IDLE) begin
			hit_q <= 1'b0;
			best_q <= 1'b0;
		end else if (state_q == ST_WALK) begin
			if (valid_q[idx] && sym_q[idx] == cmd_q.symbol && !hit_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= idx;
			end
			if (valid_q[idx] && !marked_q[idx] && (!best_q || sym_q[idx] < best_sym_q)) begin
				best_q <= 1'b1;
				best_idx_q <= idx;
				best_sym_q <= sym_q[idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_reg_q <= srpa_pkg::FIRST_REG_RESET;
			last_reg_q <= srpa_pkg::LAST_REG_RESET;
			valid_q <= '0;
			marked_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == srpa_pkg::CFG_FIRST_REG) begin
					first_reg_q <= cfg_data;
				end else begin
					last_reg_q <= cfg_data;
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q <= '0;
						if (cmd.kind == srpa_pkg::KIND_SEARCH || cmd.kind == srpa_pkg::KIND_SCAN) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (IB+1)'(N - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						valid_q <= valid_next;
						if (cmd_q.operation == srpa_pkg::OP_CLEAR
								|| cmd_q.operation == srpa_pkg::OP_RELEASE
								|| cmd_q.operation == srpa_pkg::OP_EVICT) begin
							marked_q <= '0;
						end else if (cmd_q.operation == srpa_pkg::OP_ALLOCATE
								&& !hit_q && any_free) begin
							marked_q[low_idx] <= 1'b0;
						end else if (cmd_q.operation == srpa_pkg::OP_MARK && hit_q) begin
							marked_q[hit_idx_q] <= 1'b1;
						end
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> src/symbol_register_pool_allocator.sv
// Register pool allocator that binds symbol ids to pool registers.
// Input channel: in_valid, in_stall and in_item carry one operation with
// its symbol. An item is taken when in_valid is high and in_stall is low.
// Output channel: out_valid, out_stall and out_item carry exactly one
// result for each item, in order.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 first_reg,
// 1 last_reg). The user must use it only while idle: the block does not check.
// Items pass through a two-entry queue from the front end to the execution
// unit. Clear and the unused operation codes go from idle through the finish
// and send states to their result; allocate, lookup, mark, release and evict
// first walk the table one entry per cycle over all NUM_REGS entries.
// A result waits in the output register while out_stall is high; meanwhile
// the execution unit can take one more item and the queue can hold two more.
// Reset empties the table, clears all tags and restores first_reg to 8 and
// last_reg to 25. No clearing pass is needed after reset.
module symbol_register_pool_allocator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input srpa_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output srpa_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic cfg_index,
	input logic [4:0] cfg_data
);

`include "symbol_register_pool_allocator_assert.svh"

	logic cmd_valid;
	logic cmd_take;
	srpa_pkg::cmd_t cmd;

	srpa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.cmd(cmd)
	);

	srpa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.cmd(cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	`SRPA_ASSERT_IMPL(a_err_zero_reg, clk, arst_n,
		out_valid && out_item.status != srpa_pkg::ST_OK, out_item.register_number == 5'd0,
		"failing result carries a register number")
	`SRPA_ASSERT_IMPL(a_evsym_only_ok, clk, arst_n,
		out_valid && out_item.status != srpa_pkg::ST_OK, out_item.evicted_symbol == '0,
		"failing result carries an evicted symbol")
	`SRPA_ASSERT_NEXT(a_stalled_result_held, clk, arst_n,
		out_valid && out_stall, out_valid && $stable(out_item),
		"stalled result changed")

endmodule
